FILE: rtl/core/fpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, operation codes and sizing constants for the Q24.8 ALU core.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DataW        = 32;
  localparam int ModeW        = 5;
  localparam int FracBitsDflt = 8;

  typedef enum logic [ModeW-1:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3,
    OP_EQ  = 5'd4, OP_NE  = 5'd5, OP_LE  = 5'd6, OP_GE  = 5'd7,
    OP_GT  = 5'd8, OP_LT  = 5'd9, OP_MIN = 5'd10, OP_MAX = 5'd11,
    OP_INC = 5'd12, OP_DEC = 5'd13, OP_FROM_INT = 5'd14, OP_TO_INT = 5'd15,
    OP_FROM_FLT = 5'd16, OP_TO_FLT = 5'd17
  } op_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             compare_true;
    logic             divide_by_zero;
    logic             out_of_range;
  } res_t;

endpackage : fpa_pkg
`default_nettype wire

FILE: rtl/core/fpa_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_in_if / fpa_out_if
// Valid/ready channels carrying ALU operations and ALU results.
// ----------------------------------------------------------------------------
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface : fpa_in_if

interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result;
  logic        compare_true;
  logic        divide_by_zero;
  logic        out_of_range;
  modport source (output valid, result, compare_true, divide_by_zero, out_of_range,
                  input ready);
  modport sink   (input valid, result, compare_true, divide_by_zero, out_of_range,
                  output ready);
endinterface : fpa_out_if
`default_nettype wire

FILE: rtl/core/fpa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_cell
// One stage of the chain: a restoring divide step on its own bit of the
// quotient, while the other results of the item ride along unchanged.
// ----------------------------------------------------------------------------
module fpa_cell #(
  parameter int RemW = 33,
  parameter int QW   = 48,
  parameter int BitIdx = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       vld_i,
  input  wire logic [RemW-1:0]            rem_i,
  input  wire logic [QW-1:0]              num_i,
  input  wire logic [RemW-2:0]            den_i,
  input  wire logic                       neg_i,
  input  wire logic                       is_div_i,
  input  wire fpa_pkg::res_t              res_i,
  output logic                            vld_o,
  output logic [RemW-1:0]                 rem_o,
  output logic [QW-1:0]                   num_o,
  output logic [RemW-2:0]                 den_o,
  output logic                            neg_o,
  output logic                            is_div_o,
  output fpa_pkg::res_t                   res_o
);
  import fpa_pkg::*;

  logic [RemW-1:0] trial;
  logic [RemW-1:0] diff;
  logic            fits;
  logic [QW-1:0]   num_nxt;
  logic [RemW-1:0] rem_nxt;

  always_comb begin
    trial = {rem_i[RemW-2:0], num_i[BitIdx]};
    diff  = trial - {1'b0, den_i};
    fits  = trial >= {1'b0, den_i};
    rem_nxt = fits ? diff : trial;
    num_nxt = num_i;
    num_nxt[BitIdx] = fits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (adv) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_o    <= rem_nxt;
      num_o    <= num_nxt;
      den_o    <= den_i;
      neg_o    <= neg_i;
      is_div_o <= is_div_i;
      res_o    <= res_i;
    end
  end
endmodule : fpa_cell
`default_nettype wire

FILE: rtl/core/fpa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_front
// Entry stages: decode the operation, compute the non-multiply, non-divide results,
// the float conversions and the 32x32 product magnitude (registered), then
// finish multiply and prepare the divider operands.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDflt,
  parameter int QW        = fpa_pkg::DataW + FRAC_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire logic                   vld_i,
  input  wire logic [fpa_pkg::ModeW-1:0] mode_i,
  input  wire logic [fpa_pkg::DataW-1:0] a_i,
  input  wire logic [fpa_pkg::DataW-1:0] b_i,
  output logic                        vld_o,
  output logic [QW-1:0]               num_o,
  output logic [fpa_pkg::DataW-1:0]   den_o,
  output logic                        neg_o,
  output logic                        is_div_o,
  output fpa_pkg::res_t               res_o
);
  import fpa_pkg::*;

  // ---------------- stage 1 ----------------
  logic             s_neg_a, s_neg_b;
  logic [DataW-1:0] mag_a, mag_b;
  logic signed [DataW-1:0] sa, sb;
  res_t             r1;
  logic             lt, eq;
  logic [DataW-1:0] toi;

  // from_float
  logic        f_neg;
  logic [7:0]  f_ex;
  logic [23:0] f_m;
  logic        f_oor;
  logic [DataW-1:0] f_res;
  logic signed [10:0] f_sh;
  logic [63:0] f_q;
  logic [5:0]  f_n;

  // to_float
  logic [DataW-1:0] t_u;
  logic [4:0]  t_p;
  logic [DataW-1:0] t_norm;
  logic [23:0] t_keep;
  logic [7:0]  t_low;
  logic        t_up;
  logic [24:0] t_rnd;
  logic [7:0]  t_ex;
  logic [DataW-1:0] t_res;

  always_comb begin
    sa = signed'(a_i);
    sb = signed'(b_i);
    s_neg_a = a_i[DataW-1];
    s_neg_b = b_i[DataW-1];
    mag_a = s_neg_a ? (~a_i + 1'b1) : a_i;
    mag_b = s_neg_b ? (~b_i + 1'b1) : b_i;
    lt = sa < sb;
    eq = a_i == b_i;
    toi = DataW'(sa >>> FRAC_BITS);

    // float to fixed
    f_neg = a_i[31];
    f_ex  = a_i[30:23];
    f_m   = {1'b0, a_i[22:0]};
    f_oor = 1'b0;
    f_res = '0;
    f_q   = '0;
    f_n   = '0;
    f_sh  = '0;
    if (f_ex == 8'hFF) begin
      f_oor = 1'b1;
      f_res = (a_i[22:0] != 0) ? '0 : (f_neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
    end else begin
      if (f_ex != 0) f_m[23] = 1'b1;
      f_sh = 11'(signed'({3'b0, (f_ex == 0) ? 8'd1 : f_ex})) - 11'sd150
             + 11'(FRAC_BITS);
      if (f_m != 0) begin
        if (f_sh >= 0) begin
          if (f_sh > 32) f_q = 64'h100_0000_0000;
          else f_q = {40'b0, f_m} << f_sh[5:0];
        end else if (-f_sh <= 25) begin
          f_n = 6'(-f_sh);
          f_q = ({40'b0, f_m} + (64'd1 << (f_n - 6'd1))) >> f_n;
        end
        if (!f_neg && f_q > 64'h7FFF_FFFF) begin
          f_oor = 1'b1;
          f_res = 32'h7FFF_FFFF;
        end else if (f_neg && f_q > 64'h8000_0000) begin
          f_oor = 1'b1;
          f_res = 32'h8000_0000;
        end else begin
          f_res = f_neg ? (~f_q[31:0] + 1'b1) : f_q[31:0];
        end
      end
    end

    // fixed to float: leading one, shift, round to nearest even
    t_u = mag_a;
    t_p = '0;
    for (int i = 0; i < DataW; i++) begin
      if (t_u[i]) t_p = 5'(i);
    end
    t_norm = t_u << (5'd31 - t_p);          // leading one at bit 31
    t_keep = t_norm[31:8];
    t_low  = t_norm[7:0];
    t_up   = t_low[7] && ((t_low[6:0] != 0) || t_keep[0]);
    t_rnd  = {1'b0, t_keep} + 25'(t_up);
    t_ex   = 8'(t_p) - 8'(FRAC_BITS) + 8'd127;
    if (t_rnd[24]) t_ex = t_ex + 8'd1;
    t_res  = (t_u == 0) ? '0 :
             {s_neg_a, t_ex, t_rnd[24] ? t_rnd[23:1] : t_rnd[22:0]};

    r1 = '0;
    case (mode_i)
      OP_ADD:      r1.result = a_i + b_i;
      OP_SUB:      r1.result = a_i - b_i;
      OP_EQ:       r1.compare_true = eq;
      OP_NE:       r1.compare_true = !eq;
      OP_LE:       r1.compare_true = lt || eq;
      OP_GE:       r1.compare_true = !lt;
      OP_GT:       r1.compare_true = !lt && !eq;
      OP_LT:       r1.compare_true = lt;
      OP_MIN:      r1.result = lt ? a_i : b_i;
      OP_MAX:      r1.result = (!lt && !eq) ? a_i : b_i;
      OP_INC:      r1.result = a_i + 1'b1;
      OP_DEC:      r1.result = a_i - 1'b1;
      OP_FROM_INT: r1.result = a_i << FRAC_BITS;
      OP_TO_INT:   r1.result = toi;
      OP_FROM_FLT: begin
        r1.result = f_res;
        r1.out_of_range = f_oor;
      end
      OP_TO_FLT:   r1.result = t_res;
      OP_DIV:      r1.divide_by_zero = (b_i == 0);
      default:     r1 = '0;
    endcase
    if (mode_i >= OP_EQ && mode_i <= OP_LT) r1.result = DataW'(r1.compare_true);
  end

  logic             v1_r;
  res_t             r1_r;
  logic [2*DataW-1:0] prod_r;
  logic             neg_r, is_mul_r, is_div_r;
  logic [DataW-1:0] ma_r, mb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= vld_i;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_r     <= r1;
      prod_r   <= mag_a * mag_b;
      neg_r    <= s_neg_a ^ s_neg_b;
      is_mul_r <= mode_i == OP_MUL;
      is_div_r <= (mode_i == OP_DIV) && (b_i != 0);
      ma_r     <= mag_a;
      mb_r     <= mag_b;
    end
  end

  // ---------------- stage 2 ----------------
  logic [2*DataW-1:0] psh;
  res_t r2;

  always_comb begin
    psh = prod_r >> FRAC_BITS;
    r2  = r1_r;
    if (is_mul_r) r2.result = neg_r ? (~psh[DataW-1:0] + 1'b1) : psh[DataW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_o <= 1'b0;
    else if (adv) vld_o <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_o    <= r2;
      num_o    <= {{FRAC_BITS{1'b0}}, ma_r} << FRAC_BITS;
      den_o    <= mb_r;
      neg_o    <= neg_r;
      is_div_o <= is_div_r;
    end
  end
endmodule : fpa_front
`default_nettype wire

FILE: rtl/core/fixed_point_q24_8_alu_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Pipelined signed Q24.8 ALU: arithmetic, compares, conversions.
// ----------------------------------------------------------------------------
// Takes one operation per cycle and returns one result per operation, in
// order. Every item travels the same path: two entry stages (decode, direct
// operations, float conversions, 32x32 product), then a chain of 32+FRAC_BITS
// divider cells, one quotient bit each, then an output register. The whole
// pipe advances together; it stalls only while the output register holds a
// result that is not taken, and it still accepts a new item in that cycle
// whenever the output transfer completes.
module fixed_point_q24_8_alu_core #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDflt
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpa_in_if.sink     in_ch,
  fpa_out_if.source  out_ch
);
  import fpa_pkg::*;

  localparam int QW   = DataW + FRAC_BITS;
  localparam int RemW = DataW + 1;

  logic adv;
  logic out_vld_r;
  res_t out_r;

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic          f_vld, f_neg, f_div;
  logic [QW-1:0] f_num;
  logic [DataW-1:0] f_den;
  res_t          f_res;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .vld_i(in_ch.valid), .mode_i(in_ch.mode),
    .a_i(in_ch.operand_a), .b_i(in_ch.operand_b),
    .vld_o(f_vld), .num_o(f_num), .den_o(f_den), .neg_o(f_neg),
    .is_div_o(f_div), .res_o(f_res)
  );

  logic            c_vld [QW+1];
  logic [RemW-1:0] c_rem [QW+1];
  logic [QW-1:0]   c_num [QW+1];
  logic [DataW-1:0] c_den [QW+1];
  logic            c_neg [QW+1];
  logic            c_div [QW+1];
  res_t            c_res [QW+1];

  assign c_vld[0] = f_vld;
  assign c_rem[0] = '0;
  assign c_num[0] = f_num;
  assign c_den[0] = f_den;
  assign c_neg[0] = f_neg;
  assign c_div[0] = f_div;
  assign c_res[0] = f_res;

  // MSB first: cell k decides quotient bit QW-1-k
  for (genvar k = 0; k < QW; k++) begin : g_cell
    fpa_cell #(.RemW(RemW), .QW(QW), .BitIdx(QW-1-k)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_i(c_vld[k]), .rem_i(c_rem[k]), .num_i(c_num[k]), .den_i(c_den[k]),
      .neg_i(c_neg[k]), .is_div_i(c_div[k]), .res_i(c_res[k]),
      .vld_o(c_vld[k+1]), .rem_o(c_rem[k+1]), .num_o(c_num[k+1]),
      .den_o(c_den[k+1]), .neg_o(c_neg[k+1]), .is_div_o(c_div[k+1]),
      .res_o(c_res[k+1])
    );
  end

  res_t fin;
  always_comb begin
    fin = c_res[QW];
    if (c_div[QW]) begin
      fin.result = c_neg[QW] ? (~c_num[QW][DataW-1:0] + 1'b1) : c_num[QW][DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= c_vld[QW];
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= fin;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.result         = out_r.result;
  assign out_ch.compare_true   = out_r.compare_true;
  assign out_ch.divide_by_zero = out_r.divide_by_zero;
  assign out_ch.out_of_range   = out_r.out_of_range;
endmodule : fixed_point_q24_8_alu_core
`default_nettype wire

FILE: rtl/core/fpa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the ALU core, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_result,
  input wire logic        out_compare_true,
  input wire logic        out_divide_by_zero,
  input wire logic        out_out_of_range
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result == 32'd0 && !out_compare_true
      && !out_out_of_range)
    else $error("divide by zero result not clean");

  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result == 32'd1)
    else $error("compare result mismatch");
endmodule : fpa_checker

bind fixed_point_q24_8_alu_core fpa_checker u_fpa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result(out_ch.result), .out_compare_true(out_ch.compare_true),
  .out_divide_by_zero(out_ch.divide_by_zero),
  .out_out_of_range(out_ch.out_of_range)
);
`default_nettype wire

FILE: tb/sv/fixed_point_q24_8_alu_core_test.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core_test
// Random and directed operations through the Q24.8 ALU core, each result
// checked field by field against an in-bench prediction of the operation.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core_test;
  import fpa_pkg::*;

  localparam int FracBits = 8;
  localparam int Latency  = 3 + 32 + FracBits;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [4:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
  } op_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_q24_8_alu_core #(.FRAC_BITS(FracBits)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  op_item_t pending_ops[$];
  res_t     expected_results[$];
  int       mismatches = 0;
  int       sent_ops = 0;
  int       got_results = 0;
  int       cycle_count = 0;
  int       hold_off = 0;
  bit       hold_done = 1'b0;
  bit       quiet_phase = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %h expected %h", got_results, what, got, want);
  endtask

  function automatic logic [31:0] negate_if(input logic [63:0] m, input bit neg);
    logic [63:0] v;
    v = neg ? (64'd0 - m) : m;
    return v[31:0];
  endfunction

  function automatic logic [31:0] float_to_q(input logic [31:0] bits, output bit oor);
    bit neg;
    int ex, sh, n;
    logic [63:0] m, q;
    neg = bits[31];
    ex = bits[30:23];
    m = {41'd0, bits[22:0]};
    oor = 1'b0;
    if (ex == 255) begin
      oor = 1'b1;
      if (m != 0) return 32'd0;
      return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    if (ex == 0) ex = 1;
    else m[23] = 1'b1;
    if (m == 0) return 32'd0;
    sh = ex - 150 + FracBits;
    if (sh >= 0) begin
      q = (sh > 32) ? (64'd1 << 40) : (m << sh);
    end else begin
      n = -sh;
      if (n > 25) return 32'd0;
      q = (m + (64'd1 << (n - 1))) >> n;
    end
    if (!neg && q > 64'h7fff_ffff) begin
      oor = 1'b1;
      return 32'h7fff_ffff;
    end
    if (neg && q > 64'h8000_0000) begin
      oor = 1'b1;
      return 32'h8000_0000;
    end
    return negate_if(q, neg);
  endfunction

  function automatic logic [31:0] q_to_float(input logic signed [31:0] a);
    logic [63:0] u, keep, rem, half;
    int p, s;
    u = a < 0 ? -64'(a) : 64'(a);
    p = 0;
    if (u == 0) return 32'd0;
    while (p < 31 && (u >> (p + 1)) != 0) p++;
    if (p <= 23) begin
      keep = u << (23 - p);
    end else begin
      s = p - 23;
      rem = u & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      keep = u >> s;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep == (64'd1 << 24)) begin
        keep >>= 1;
        p++;
      end
    end
    return {a[31], 8'(p - FracBits + 127), keep[22:0]};
  endfunction

  function automatic res_t alu_outcome(input op_item_t it);
    res_t r;
    logic signed [31:0] a, b;
    logic [63:0] ma, mb;
    bit cmp_mode, oor;
    a = it.a;
    b = it.b;
    ma = a < 0 ? -64'(a) : 64'(a);
    mb = b < 0 ? -64'(b) : 64'(b);
    r = '0;
    cmp_mode = 1'b0;
    case (it.mode)
      OP_ADD: r.result = it.a + it.b;
      OP_SUB: r.result = it.a - it.b;
      OP_MUL: r.result = negate_if((ma * mb) >> FracBits, (a < 0) != (b < 0));
      OP_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result = negate_if((ma << FracBits) / mb, (a < 0) != (b < 0));
      end
      OP_EQ: begin cmp_mode = 1; r.compare_true = a == b; end
      OP_NE: begin cmp_mode = 1; r.compare_true = a != b; end
      OP_LE: begin cmp_mode = 1; r.compare_true = a <= b; end
      OP_GE: begin cmp_mode = 1; r.compare_true = a >= b; end
      OP_GT: begin cmp_mode = 1; r.compare_true = a > b; end
      OP_LT: begin cmp_mode = 1; r.compare_true = a < b; end
      OP_MIN: r.result = a < b ? it.a : it.b;
      OP_MAX: r.result = a > b ? it.a : it.b;
      OP_INC: r.result = it.a + 32'd1;
      OP_DEC: r.result = it.a - 32'd1;
      OP_FROM_INT: r.result = it.a << FracBits;
      OP_TO_INT: r.result = a >>> FracBits;
      OP_FROM_FLT: begin
        r.result = float_to_q(it.a, oor);
        r.out_of_range = oor;
      end
      OP_TO_FLT: r.result = q_to_float(a);
      default: r = '0;
    endcase
    if (cmp_mode) r.result = {31'd0, r.compare_true};
    return r;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 1024)) - 512);
      4: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'hff;
      1: f[30:23] = 8'h00;
      2: f[30:23] = 8'($urandom_range(150, 170));
      default: f[30:23] = 8'($urandom_range(100, 160));
    endcase
    return f;
  endfunction

  task automatic queue_op(input logic [4:0] m, input logic [31:0] a, input logic [31:0] b);
    op_item_t it;
    it.mode = m;
    it.a = a;
    it.b = b;
    pending_ops.push_back(it);
  endtask

  // transfer is sampled at the rising edge; the driver side acts on the falling edge
  logic in_fire;
  always @(posedge clk) in_fire <= in_ch.valid && in_ch.ready;

  // driver: present the head of the queue, hold it until the transfer, then drop it
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) begin
        expected_results.push_back(alu_outcome({in_ch.mode, in_ch.operand_a, in_ch.operand_b}));
        void'(pending_ops.pop_front());
        sent_ops++;
      end
      if (in_ch.valid && !in_fire) begin
        in_ch.valid <= 1'b1;
      end else if (pending_ops.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 22)) begin
        in_ch.valid <= 1'b1;
        in_ch.mode <= pending_ops[0].mode;
        in_ch.operand_a <= pending_ops[0].a;
        in_ch.operand_b <= pending_ops[0].b;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall, including one long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (rst_n && sent_ops >= 150 && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 120;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_phase || $urandom_range(0, 99) >= 22;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_ch.result, 32'd0);
      end else begin
        if (out_ch.result !== expected_results[0].result)
          report("result", out_ch.result, expected_results[0].result);
        if (out_ch.compare_true !== expected_results[0].compare_true)
          report("compare_true", out_ch.compare_true, expected_results[0].compare_true);
        if (out_ch.divide_by_zero !== expected_results[0].divide_by_zero)
          report("divide_by_zero", out_ch.divide_by_zero, expected_results[0].divide_by_zero);
        if (out_ch.out_of_range !== expected_results[0].out_of_range)
          report("out_of_range", out_ch.out_of_range, expected_results[0].out_of_range);
        void'(expected_results.pop_front());
      end
      got_results <= got_results + 1;
    end
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("fixed_point_q24_8_alu_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    logic [4:0] m;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    // directed corners
    queue_op(OP_ADD, 32'h7fff_ffff, 32'd1);
    queue_op(OP_SUB, 32'h8000_0000, 32'd1);
    queue_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_op(OP_MUL, 32'hffff_ff00, 32'h0000_0180);
    queue_op(OP_DIV, 32'h0000_0500, 32'd0);
    queue_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    queue_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    queue_op(OP_EQ, 32'd5, 32'd5);
    queue_op(OP_NE, 32'd5, 32'd5);
    queue_op(OP_LE, 32'h8000_0000, 32'h7fff_ffff);
    queue_op(OP_GE, 32'h8000_0000, 32'h7fff_ffff);
    queue_op(OP_GT, 32'd0, 32'hffff_ffff);
    queue_op(OP_LT, 32'd7, 32'd7);
    queue_op(OP_MIN, 32'h8000_0000, 32'd3);
    queue_op(OP_MAX, 32'h8000_0000, 32'd3);
    queue_op(OP_INC, 32'h7fff_ffff, 32'd0);
    queue_op(OP_DEC, 32'h8000_0000, 32'd0);
    queue_op(OP_FROM_INT, 32'hffff_ffff, 32'd0);
    queue_op(OP_TO_INT, 32'hffff_ff01, 32'd0);
    queue_op(OP_FROM_FLT, 32'h7f80_0000, 32'd0);
    queue_op(OP_FROM_FLT, 32'hff80_0000, 32'd0);
    queue_op(OP_FROM_FLT, 32'h7fc0_0001, 32'd0);
    queue_op(OP_FROM_FLT, 32'h3b80_0000, 32'd0);
    queue_op(OP_TO_FLT, 32'h8000_0000, 32'd0);
    queue_op(5'd31, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 550; i++) begin
      m = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                         : 5'($urandom_range(0, 17));
      if (m == OP_FROM_FLT) queue_op(m, random_float(), $urandom);
      else if (m == OP_DIV && $urandom_range(0, 7) == 0) queue_op(m, random_operand(), 32'd0);
      else queue_op(m, random_operand(), random_operand());
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // no idling through the middle stretch
    wait (sent_ops >= 300);
    quiet_phase = 1'b1;
    wait (sent_ops >= 420);
    quiet_phase = 1'b0;
    wait (pending_ops.size() == 0);
    wait (expected_results.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("sent %0d operations covering all modes, received %0d results", sent_ops,
             got_results);
    $display("included a %0d-cycle output hold-off and a run with no idle cycles", 120);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fixed_point_q24_8_alu_core_test OK");
    end else begin
      $display("fixed_point_q24_8_alu_core_test NOT OK");
    end
    $finish;
  end

endmodule : fixed_point_q24_8_alu_core_test

FILE: sim.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_if.sv
rtl/core/fpa_cell.sv
rtl/core/fpa_front.sv
rtl/core/fixed_point_q24_8_alu_core.sv
rtl/core/fpa_checker.sv
tb/sv/fixed_point_q24_8_alu_core_test.sv
